### sv/skf_pkg.sv
// ----------------------------------------------------------------------------
// skf_pkg
// Shared widths, reset figures, register indexes and transaction types of the
// scalar state-of-charge Kalman filter.
// ----------------------------------------------------------------------------
package skf_pkg;

	localparam int unsigned DATA_W        = 32;
	localparam int unsigned MUL_W         = DATA_W + 1;
	localparam int unsigned ACC_W         = 2 * MUL_W + 2;
	localparam int unsigned FRAC_BITS_DEF = 16;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	// reset figures in Q16.16, rescaled to the fraction width at the top level
	localparam longint unsigned PROC_NOISE_RST_Q16 = 655;
	localparam longint unsigned MEAS_NOISE_RST_Q16 = 65536;
	localparam longint unsigned RESISTANCE_RST_Q16 = 78643;
	localparam longint unsigned SLOPE_GAIN_RST_Q16 = 6554;
	localparam longint unsigned SLOPE_OFF_RST_Q16  = 196608;
	localparam logic [31:0]     CUR_SCALE_RST      = 32'd261888;
	localparam logic [31:0]     COV_RST_UNITS      = 32'd10;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PROCESS_NOISE       = 3'd0,
		CFG_MEASUREMENT_NOISE   = 3'd1,
		CFG_CURRENT_SCALE       = 3'd2,
		CFG_INTERNAL_RESISTANCE = 3'd3,
		CFG_SLOPE_GAIN          = 3'd4,
		CFG_SLOPE_OFFSET        = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] terminal_voltage;
		logic signed [DATA_W-1:0] cell_current;
	} skf_in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] charge_estimate;
		logic                     saturated;
	} skf_out_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

	typedef struct packed {
		logic                     ovf;
		logic signed [DATA_W-1:0] val;
	} sat_t;

endpackage

### sv/skf_stream_if.sv
// ----------------------------------------------------------------------------
// skf_stream_if
// Valid/ready stream channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface skf_stream_if #(
	parameter type T = logic
);

	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);

endinterface

### sv/skf_smul.sv
// ----------------------------------------------------------------------------
// skf_smul
// Bit-serial signed multiplier: one multiplier bit per cycle, shift-add into a
// product register, sign bit of the multiplier weighted negative.
// ----------------------------------------------------------------------------
module skf_smul #(
	parameter int unsigned OP_W = skf_pkg::MUL_W
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [OP_W-1:0]    a,
	input  logic signed [OP_W-1:0]    b,
	output skf_pkg::unit_sts_t        sts,
	output logic signed [2*OP_W-1:0]  prod
);
	import skf_pkg::*;

	localparam int unsigned CNT_W = $clog2(OP_W);

	logic signed [OP_W-1:0]   a_q;
	logic [OP_W-1:0]          b_q;
	logic signed [2*OP_W-1:0] acc_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     busy_q;
	logic                     done_q;

	logic                     last;
	logic signed [OP_W:0]     part;
	logic signed [OP_W:0]     upper;
	logic signed [OP_W:0]     sum;

	always_comb begin
		last  = (cnt_q == CNT_W'(OP_W - 1));
		part  = b_q[0] ? (OP_W + 1)'(a_q) : '0;
		upper = (OP_W + 1)'($signed(acc_q[2*OP_W-1:OP_W]));
		sum   = last ? (upper - part) : (upper + part);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= {sum, acc_q[OP_W-1:1]};
			b_q   <= {1'b0, b_q[OP_W-1:1]};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign prod     = acc_q;

endmodule

### sv/skf_sdiv.sv
// ----------------------------------------------------------------------------
// skf_sdiv
// Bit-serial restoring divider for the gain: (num << FRAC_BITS) / den,
// truncated toward zero and clamped to the signed data range.
// ----------------------------------------------------------------------------
module skf_sdiv #(
	parameter int unsigned FRAC_BITS = skf_pkg::FRAC_BITS_DEF,
	parameter int unsigned DEN_W     = 2 * skf_pkg::DATA_W - skf_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [skf_pkg::DATA_W-1:0] num,
	input  logic signed [DEN_W-1:0]           den,
	output skf_pkg::unit_sts_t                sts,
	output logic signed [skf_pkg::DATA_W-1:0] quot,
	output logic                              ovf
);
	import skf_pkg::*;

	localparam int unsigned NUM_W = DATA_W + FRAC_BITS;
	localparam int unsigned CNT_W = $clog2(NUM_W);

	logic [NUM_W-1:0]  dvd_q;
	logic [DEN_W-1:0]  dv_q;
	logic [DEN_W-1:0]  rem_q;
	logic [NUM_W-1:0]  quo_q;
	logic              neg_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [DATA_W-1:0] num_mag;
	logic [DEN_W-1:0]  den_mag;
	logic [DEN_W:0]    trial;
	logic [DEN_W:0]    diff;
	logic              take;
	logic              last;
	logic              hi_nz;
	logic [DATA_W-1:0] q_lo;

	always_comb begin
		num_mag = num[DATA_W-1] ? (DATA_W'(0) - num) : num;
		den_mag = den[DEN_W-1] ? (DEN_W'(0) - den) : den;
		trial   = {rem_q, dvd_q[NUM_W-1]};
		diff    = trial - {1'b0, dv_q};
		take    = !diff[DEN_W];
		last    = (cnt_q == CNT_W'(NUM_W - 1));
		hi_nz   = |quo_q[NUM_W-1:DATA_W];
		q_lo    = quo_q[DATA_W-1:0];
		if (neg_q) begin
			ovf  = hi_nz || (q_lo[DATA_W-1] && (|q_lo[DATA_W-2:0]));
			quot = ovf ? {1'b1, {(DATA_W-1){1'b0}}} : (DATA_W'(0) - q_lo);
		end else begin
			ovf  = hi_nz || q_lo[DATA_W-1];
			quot = ovf ? {1'b0, {(DATA_W-1){1'b1}}} : q_lo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {num_mag, {FRAC_BITS{1'b0}}};
			dv_q  <= den_mag;
			rem_q <= '0;
			quo_q <= '0;
			neg_q <= num[DATA_W-1] ^ den[DEN_W-1];
		end else if (busy_q) begin
			rem_q <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], take};
			dvd_q <= {dvd_q[NUM_W-2:0], 1'b0};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

### sv/soc_scalar_kalman_filter.sv
// ----------------------------------------------------------------------------
// soc_scalar_kalman_filter
// A sample is accepted only in the idle state, once the last estimate is in
// the output register. Each sample takes eight passes through the shared
// bit-serial multiplier and one bit-serial divide of 32 + FRAC_BITS steps,
// skipped when the gain denominator is zero. An estimate waiting in the
// output register does not hold off the next sample, though that sample's
// estimate waits for it to be taken. Reset is asynchronous: registers return
// to their rescaled defaults, charge 0.5, covariance 10.0, last current 0.
// ----------------------------------------------------------------------------
module soc_scalar_kalman_filter #(
	parameter int unsigned FRAC_BITS = skf_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [skf_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [skf_pkg::CFG_DATA_W-1:0] wr_data,
	skf_stream_if.sink                    sample,
	skf_stream_if.source                  estimate
);
	import skf_pkg::*;

	localparam int unsigned DEN_W = 2 * DATA_W - FRAC_BITS;

	localparam logic [63:0] PN_RST_W = (64'(PROC_NOISE_RST_Q16) << FRAC_BITS) >> 16;
	localparam logic [63:0] MN_RST_W = (64'(MEAS_NOISE_RST_Q16) << FRAC_BITS) >> 16;
	localparam logic [63:0] RS_RST_W = (64'(RESISTANCE_RST_Q16) << FRAC_BITS) >> 16;
	localparam logic [63:0] SG_RST_W = (64'(SLOPE_GAIN_RST_Q16) << FRAC_BITS) >> 16;
	localparam logic [63:0] SO_RST_W = (64'(SLOPE_OFF_RST_Q16) << FRAC_BITS) >> 16;
	localparam logic [DATA_W-1:0] CS_RST  = DATA_W'(1) << (FRAC_BITS - 1);
	localparam logic [DATA_W-1:0] COV_RST = COV_RST_UNITS << FRAC_BITS;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_ISSUE  = 6'b000010,
		ST_WAIT   = 6'b000100,
		ST_DSTART = 6'b001000,
		ST_DWAIT  = 6'b010000,
		ST_FIN    = 6'b100000
	} state_t;

	typedef enum logic [2:0] {
		OP_PRED  = 3'd0,
		OP_SLOPE = 3'd1,
		OP_HPRED = 3'd2,
		OP_RCUR  = 3'd3,
		OP_NUM   = 3'd4,
		OP_DEN   = 3'd5,
		OP_EST   = 3'd6,
		OP_COV   = 3'd7
	} op_t;

	function automatic logic signed [ACC_W-1:0] rnd_shift(
		input logic signed [ACC_W-1:0] x,
		input int unsigned             s
	);
		logic signed [ACC_W-1:0] t;
		t = x + $signed(ACC_W'(1) << (s - 1));
		return t >>> s;
	endfunction

	function automatic sat_t sat32(input logic signed [ACC_W-1:0] x);
		sat_t r;
		r.ovf = !((&x[ACC_W-1:DATA_W-1]) || !(|x[ACC_W-1:DATA_W-1]));
		if (r.ovf) begin
			r.val = x[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
		end else begin
			r.val = x[DATA_W-1:0];
		end
		return r;
	endfunction

	// configuration
	logic [30:0]              pnoise_q;
	logic [30:0]              mnoise_q;
	logic [31:0]              cscale_q;
	logic [30:0]              res_q;
	logic signed [DATA_W-1:0] sgain_q;
	logic signed [DATA_W-1:0] soff_q;

	// filter state
	logic signed [DATA_W-1:0] cs_q;
	logic signed [DATA_W-1:0] cov_q;
	logic signed [DATA_W-1:0] prev_cur_q;

	// sequencer
	state_t state_q;
	op_t    op_q;
	logic   out_valid_q;

	// working registers of one transaction
	logic signed [DATA_W-1:0]  vt_q;
	logic signed [DATA_W-1:0]  cur_q;
	logic signed [DATA_W-1:0]  ppred_q;
	logic signed [DATA_W-1:0]  pred_q;
	logic signed [DATA_W-1:0]  h_q;
	logic signed [2*MUL_W-1:0] hp_q;
	logic signed [DATA_W-1:0]  ypred_q;
	logic signed [DATA_W-1:0]  num_q;
	logic signed [DATA_W-1:0]  innov_q;
	logic signed [DEN_W-1:0]   den_q;
	logic signed [DATA_W-1:0]  gain_q;
	logic signed [DATA_W-1:0]  est_q;
	logic signed [DATA_W-1:0]  pnew_q;
	logic                      flag_q;
	skf_out_t                  out_q;

	logic                      accept;
	logic                      load_out;
	logic                      mul_start;
	logic                      mul_done;
	logic                      div_start;
	logic signed [MUL_W-1:0]   mul_a;
	logic signed [MUL_W-1:0]   mul_b;
	logic signed [2*MUL_W-1:0] prod;
	unit_sts_t                 mul_sts;
	unit_sts_t                 div_sts;
	logic signed [DATA_W-1:0]  div_quot;
	logic                      div_ovf;

	logic signed [ACC_W-1:0]   prod_x;
	logic signed [ACC_W-1:0]   rnd_f;
	logic signed [ACC_W-1:0]   den_x;
	logic                      den_zero;
	sat_t                      s_pp;
	sat_t                      s_pred;
	sat_t                      s_h;
	sat_t                      s_y;
	sat_t                      s_num;
	sat_t                      s_innov;
	sat_t                      s_est;
	sat_t                      s_cov;

	assign accept    = sample.valid && sample.ready;
	assign load_out  = (state_q == ST_FIN) && (!out_valid_q || estimate.ready);
	assign mul_start = (state_q == ST_ISSUE);
	assign mul_done  = (state_q == ST_WAIT) && mul_sts.done;
	assign div_start = (state_q == ST_DSTART);

	assign sample.ready   = (state_q == ST_IDLE);
	assign estimate.valid = out_valid_q;
	assign estimate.data  = out_q;

	always_comb begin
		case (op_q)
			OP_PRED: begin
				mul_a = MUL_W'(prev_cur_q);
				mul_b = $signed({1'b0, cscale_q});
			end
			OP_SLOPE: begin
				mul_a = MUL_W'(sgain_q);
				mul_b = MUL_W'(pred_q);
			end
			OP_HPRED: begin
				mul_a = MUL_W'(h_q);
				mul_b = MUL_W'(pred_q);
			end
			OP_RCUR: begin
				mul_a = $signed({2'b00, res_q});
				mul_b = MUL_W'(cur_q);
			end
			OP_NUM: begin
				mul_a = MUL_W'(ppred_q);
				mul_b = MUL_W'(h_q);
			end
			OP_DEN: begin
				mul_a = MUL_W'(h_q);
				mul_b = MUL_W'(num_q);
			end
			OP_EST: begin
				mul_a = MUL_W'(gain_q);
				mul_b = MUL_W'(innov_q);
			end
			OP_COV: begin
				mul_a = MUL_W'(gain_q);
				mul_b = MUL_W'(num_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		prod_x   = ACC_W'(prod);
		rnd_f    = rnd_shift(prod_x, FRAC_BITS);
		den_x    = rnd_f + ACC_W'($signed({1'b0, mnoise_q}));
		den_zero = (den_x == '0);
		s_pp     = sat32(ACC_W'(cov_q) + ACC_W'($signed({1'b0, pnoise_q})));
		s_pred   = sat32(ACC_W'(cs_q) + rnd_shift(prod_x, DATA_W));
		s_h      = sat32(rnd_f + ACC_W'(soff_q));
		s_y      = sat32(rnd_shift(ACC_W'(hp_q) - prod_x, FRAC_BITS));
		s_num    = sat32(rnd_f);
		s_innov  = sat32(ACC_W'(vt_q) - ACC_W'(ypred_q));
		s_est    = sat32(ACC_W'(pred_q) + rnd_f);
		s_cov    = sat32(ACC_W'(ppred_q) - rnd_f);
	end

	skf_smul #(
		.OP_W (MUL_W)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.sts    (mul_sts),
		.prod   (prod)
	);

	skf_sdiv #(
		.FRAC_BITS (FRAC_BITS),
		.DEN_W     (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (den_q),
		.sts    (div_sts),
		.quot   (div_quot),
		.ovf    (div_ovf)
	);

	// sequencer, filter state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_PRED;
			out_valid_q <= 1'b0;
			cs_q        <= CS_RST;
			cov_q       <= COV_RST;
			prev_cur_q  <= '0;
			pnoise_q    <= PN_RST_W[30:0];
			mnoise_q    <= MN_RST_W[30:0];
			cscale_q    <= CUR_SCALE_RST;
			res_q       <= RS_RST_W[30:0];
			sgain_q     <= $signed({1'b0, SG_RST_W[30:0]});
			soff_q      <= $signed({1'b0, SO_RST_W[30:0]});
		end else begin
			if (wr_en) begin
				case (cfg_idx_t'(wr_index))
					CFG_PROCESS_NOISE:       pnoise_q <= wr_data[30:0];
					CFG_MEASUREMENT_NOISE:   mnoise_q <= wr_data[30:0];
					CFG_CURRENT_SCALE:       cscale_q <= wr_data;
					CFG_INTERNAL_RESISTANCE: res_q    <= wr_data[30:0];
					CFG_SLOPE_GAIN:          sgain_q  <= $signed(wr_data);
					CFG_SLOPE_OFFSET:        soff_q   <= $signed(wr_data);
					default: ;
				endcase
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (estimate.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q    <= OP_PRED;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (mul_sts.done) begin
						case (op_q)
							OP_PRED: begin
								op_q    <= OP_SLOPE;
								state_q <= ST_ISSUE;
							end
							OP_SLOPE: begin
								op_q    <= OP_HPRED;
								state_q <= ST_ISSUE;
							end
							OP_HPRED: begin
								op_q    <= OP_RCUR;
								state_q <= ST_ISSUE;
							end
							OP_RCUR: begin
								op_q    <= OP_NUM;
								state_q <= ST_ISSUE;
							end
							OP_NUM: begin
								op_q    <= OP_DEN;
								state_q <= ST_ISSUE;
							end
							OP_DEN: begin
								op_q    <= OP_EST;
								state_q <= den_zero ? ST_ISSUE : ST_DSTART;
							end
							OP_EST: begin
								op_q    <= OP_COV;
								state_q <= ST_ISSUE;
							end
							OP_COV: begin
								state_q <= ST_FIN;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_DSTART: begin
					state_q <= ST_DWAIT;
				end
				ST_DWAIT: begin
					if (div_sts.done) begin
						state_q <= ST_ISSUE;
					end
				end
				ST_FIN: begin
					if (load_out) begin
						cs_q       <= est_q;
						cov_q      <= pnew_q;
						prev_cur_q <= cur_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath of the transaction in flight
	always_ff @(posedge clk) begin
		if (accept) begin
			vt_q    <= sample.data.terminal_voltage;
			cur_q   <= sample.data.cell_current;
			ppred_q <= s_pp.val;
			flag_q  <= s_pp.ovf;
		end

		if (mul_done) begin
			case (op_q)
				OP_PRED: begin
					pred_q <= s_pred.val;
					flag_q <= flag_q | s_pred.ovf;
				end
				OP_SLOPE: begin
					h_q    <= s_h.val;
					flag_q <= flag_q | s_h.ovf;
				end
				OP_HPRED: begin
					hp_q <= prod;
				end
				OP_RCUR: begin
					ypred_q <= s_y.val;
					flag_q  <= flag_q | s_y.ovf;
				end
				OP_NUM: begin
					num_q   <= s_num.val;
					innov_q <= s_innov.val;
					flag_q  <= flag_q | s_num.ovf | s_innov.ovf;
				end
				OP_DEN: begin
					den_q <= den_x[DEN_W-1:0];
					if (den_zero) begin
						gain_q <= '0;
						flag_q <= 1'b1;
					end
				end
				OP_EST: begin
					est_q  <= s_est.val;
					flag_q <= flag_q | s_est.ovf;
				end
				OP_COV: begin
					pnew_q <= s_cov.val;
					flag_q <= flag_q | s_cov.ovf;
				end
				default: ;
			endcase
		end

		if ((state_q == ST_DWAIT) && div_sts.done) begin
			gain_q <= div_quot;
			flag_q <= flag_q | div_ovf;
		end

		if (load_out) begin
			out_q.charge_estimate <= est_q;
			out_q.saturated       <= flag_q;
		end
	end

`ifndef SYNTH
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_ISSUE) && (op_q == OP_PRED))
		else $error("sample transaction did not start the sequence");

	a_mul_free: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> !mul_sts.busy)
		else $error("multiplier started while busy");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (den_q != '0) && !div_sts.busy)
		else $error("divide started on a zero or busy divider");

	a_fin_loads: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid_q && (state_q == ST_IDLE))
		else $error("finished estimate not presented");
`endif

endmodule
